// ----- rtl/core/blde_pkg.sv -----
// Shared types, constants and the control store for the bounded deque engine.
// Depends on nothing; every file of the block imports it.
`timescale 1ns / 1ps

package blde_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int REQ_W   = 3;
  localparam int POS_W   = 8;
  localparam int OUT_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_REM_FIRST = 3'd1,
    REQ_REM_LAST  = 3'd2,
    REQ_REM_POS   = 3'd3,
    REQ_LIST      = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Sequencer steps (program counter values).
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_APPEND    = 4'd1,
    S_APPEND_WR = 4'd2,
    S_REM_LAST  = 4'd3,
    S_REM_FIRST = 4'd4,
    S_REM_POS   = 4'd5,
    S_SH_PRIME  = 4'd6,
    S_SH_LOOP   = 4'd7,
    S_DEC       = 4'd8,
    S_LIST      = 4'd9,
    S_LS_PRIME  = 4'd10,
    S_LS_LOOP   = 4'd11,
    S_SINGLE    = 4'd12
  } step_t;

  typedef enum logic [1:0] {EMIT_NONE, EMIT_STATUS, EMIT_ITEM} emit_t;
  typedef enum logic [1:0] {RD_NONE, RD_PTR, RD_PTR1, RD_PTR2} rd_t;
  typedef enum logic [1:0] {WR_NONE, WR_TAIL, WR_SHIFT} wr_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {PTR_HOLD, PTR_ZERO, PTR_POS, PTR_INC} ptr_op_t;
  // C_END1: ptr + 1 reaches the count; C_END2: ptr + 2 reaches the count.
  typedef enum logic [2:0] {C_ALWAYS, C_INPUT, C_ERR, C_END1, C_END2} cond_t;

  typedef struct packed {
    emit_t   emit;
    rd_t     rd;
    wr_t     wr;
    cnt_op_t cnt_op;
    ptr_op_t ptr_op;
    cond_t   cond;
    step_t   jmp;   // taken when cond holds
    step_t   nxt;   // taken otherwise
  } ucode_t;

  function automatic ucode_t uc_word(emit_t e, rd_t r, wr_t w, cnt_op_t c,
                                     ptr_op_t p, cond_t cd, step_t j, step_t n);
    ucode_t u;
    u = '{emit: e, rd: r, wr: w, cnt_op: c, ptr_op: p, cond: cd, jmp: j, nxt: n};
    return u;
  endfunction

  // Control store: one word per step.
  function automatic ucode_t uc_rom(step_t s);
    ucode_t u;
    unique case (s)
      S_IDLE:      u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_INPUT, S_IDLE, S_IDLE);
      S_APPEND:    u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_ERR, S_SINGLE, S_APPEND_WR);
      S_APPEND_WR: u = uc_word(EMIT_NONE, RD_NONE, WR_TAIL, CNT_INC, PTR_HOLD,
                               C_ALWAYS, S_SINGLE, S_SINGLE);
      S_REM_LAST:  u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_ERR, S_SINGLE, S_DEC);
      S_REM_FIRST: u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_ZERO,
                               C_ERR, S_SINGLE, S_SH_PRIME);
      S_REM_POS:   u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_POS,
                               C_ERR, S_SINGLE, S_SH_PRIME);
      S_SH_PRIME:  u = uc_word(EMIT_NONE, RD_PTR1, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_END1, S_DEC, S_SH_LOOP);
      S_SH_LOOP:   u = uc_word(EMIT_NONE, RD_PTR2, WR_SHIFT, CNT_HOLD, PTR_INC,
                               C_END2, S_DEC, S_SH_LOOP);
      S_DEC:       u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_DEC, PTR_HOLD,
                               C_ALWAYS, S_SINGLE, S_SINGLE);
      S_LIST:      u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_ZERO,
                               C_ERR, S_SINGLE, S_LS_PRIME);
      S_LS_PRIME:  u = uc_word(EMIT_NONE, RD_PTR, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_ALWAYS, S_LS_LOOP, S_LS_LOOP);
      S_LS_LOOP:   u = uc_word(EMIT_ITEM, RD_PTR1, WR_NONE, CNT_HOLD, PTR_INC,
                               C_END1, S_IDLE, S_LS_LOOP);
      S_SINGLE:    u = uc_word(EMIT_STATUS, RD_NONE, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_ALWAYS, S_IDLE, S_IDLE);
      default:     u = uc_word(EMIT_NONE, RD_NONE, WR_NONE, CNT_HOLD, PTR_HOLD,
                               C_ALWAYS, S_IDLE, S_IDLE);
    endcase
    return u;
  endfunction

  // First step of the routine for each request code.
  function automatic step_t entry_step(logic [REQ_W-1:0] req);
    step_t s;
    unique case (req)
      REQ_APPEND:    s = S_APPEND;
      REQ_REM_FIRST: s = S_REM_FIRST;
      REQ_REM_LAST:  s = S_REM_LAST;
      REQ_REM_POS:   s = S_REM_POS;
      REQ_LIST:      s = S_LIST;
      default:       s = S_SINGLE;
    endcase
    return s;
  endfunction

  // Sign-extend (or trim) a stored word to the result width.
  function automatic logic [OUT_W-1:0] widen_word(logic signed [DATA_WIDTH-1:0] w);
    return OUT_W'(w);
  endfunction

endpackage

// ----- rtl/core/bounded_list_deque_engine.sv -----
// Top level of the bounded deque engine: microcoded sequencer, entry memory
// and result register. Depends on blde_pkg.
`timescale 1ns / 1ps

// Bounded ordered store of up to DEPTH signed words with append, remove
// first, remove last, remove at a zero-based position and list. One request
// is taken at a time; in_ready is high only while the sequencer sits at its
// idle step. Every request yields one result carrying a status and the entry
// count after the request, except a list of a non-empty store, which yields
// one result per entry, first to last, the last one flagged. The entry
// memory, with one write port and one registered read port, sets the pace:
// one entry is moved or read per cycle, save while a list step holds for a
// full result register, and each result transfer waits for the output
// register to drain. The result register lets the next request be
// accepted while the final result still waits.
module bounded_list_deque_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [blde_pkg::REQ_W-1:0]          req_type,
  input  logic signed [31:0]                  value_in,
  input  logic [blde_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [blde_pkg::OUT_W-1:0]   item_value,
  output logic [blde_pkg::STAT_W-1:0]         status,
  output logic [blde_pkg::COUNT_W-1:0]        entry_count,
  output logic                                carries_item,
  output logic                                last_result
);
  import blde_pkg::*;

  // Sequencer state and datapath registers.
  step_t                  pc, pc_next;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       ptr;
  status_t                status_r;
  logic [DATA_WIDTH-1:0]  value_r;
  logic [POS_W-1:0]       position_r;

  // Entry memory with registered read.
  logic [DATA_WIDTH-1:0]  mem [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data;

  ucode_t                 uc;
  logic                   in_xfer;
  logic                   stall;
  logic                   cond_hit;
  logic [CNT_W:0]         ptr_p1, ptr_p2, cnt_x;
  logic                   end1, end2;
  status_t                status_new;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]  wr_data;

  assign in_ready = (pc == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign ptr_p1 = (CNT_W+1)'(ptr) + (CNT_W+1)'(1);
  assign ptr_p2 = (CNT_W+1)'(ptr) + (CNT_W+1)'(2);
  assign cnt_x  = (CNT_W+1)'(cnt);
  assign end1   = (ptr_p1 >= cnt_x);
  assign end2   = (ptr_p2 >= cnt_x);

  // Judge the request against the current count when it is accepted.
  always_comb begin
    status_new = ST_DONE;
    unique case (req_type)
      REQ_APPEND: begin
        if (cnt >= CNT_W'(DEPTH)) status_new = ST_FULL;
      end
      REQ_REM_FIRST, REQ_REM_LAST, REQ_LIST: begin
        if (cnt == '0) status_new = ST_EMPTY;
      end
      REQ_REM_POS: begin
        priority if (cnt == '0) status_new = ST_EMPTY;
        else if (CMP_W'(position) >= CMP_W'(cnt)) status_new = ST_RANGE;
        else status_new = ST_DONE;
      end
      default: status_new = ST_DONE;
    endcase
  end

  // Next step.
  always_comb begin
    uc = uc_rom(pc);
    unique case (uc.cond)
      C_ALWAYS: cond_hit = 1'b1;
      C_INPUT:  cond_hit = in_xfer;
      C_ERR:    cond_hit = (status_r != ST_DONE);
      C_END1:   cond_hit = end1;
      C_END2:   cond_hit = end2;
      default:  cond_hit = 1'b1;
    endcase
    priority if (stall)            pc_next = pc;
    else if (uc.cond == C_INPUT)   pc_next = in_xfer ? entry_step(req_type) : S_IDLE;
    else if (cond_hit)             pc_next = uc.jmp;
    else                           pc_next = uc.nxt;
  end

  // Decode of the control word into datapath strobes. A step that emits
  // holds, with all its actions, while the result register is still full.
  always_comb begin
    stall   = (uc.emit != EMIT_NONE) && out_valid && !out_ready;
    mem_we  = !stall && (uc.wr != WR_NONE);
    mem_re  = !stall && (uc.rd != RD_NONE);
    wr_addr = (uc.wr == WR_TAIL) ? cnt[IDX_W-1:0] : ptr[IDX_W-1:0];
    wr_data = (uc.wr == WR_TAIL) ? value_r : rd_data;
    unique case (uc.rd)
      RD_PTR1: rd_addr = ptr_p1[IDX_W-1:0];
      RD_PTR2: rd_addr = ptr_p2[IDX_W-1:0];
      default: rd_addr = ptr[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Count and position pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (!stall) begin
      unique case (uc.cnt_op)
        CNT_INC: cnt <= cnt + CNT_W'(1);
        CNT_DEC: cnt <= cnt - CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      unique case (uc.ptr_op)
        PTR_ZERO: ptr <= '0;
        PTR_POS:  ptr <= CNT_W'(position_r);
        PTR_INC:  ptr <= ptr + CNT_W'(1);
        default:  ptr <= ptr;
      endcase
    end
  end

  // Capture the request on its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_r <= ST_DONE;
    end else if (in_xfer) begin
      status_r <= status_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      value_r    <= DATA_WIDTH'(value_in);
      position_r <= position;
    end
  end

  // Entry memory: one write and one registered read per cycle. A shift step
  // writes slot ptr with the word read from slot ptr + 1 the cycle before.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data <= mem[rd_addr];
  end

  // Result register: load on an emit step, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.emit != EMIT_NONE && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.emit != EMIT_NONE && !stall) begin
      entry_count <= COUNT_W'(cnt);
      if (uc.emit == EMIT_ITEM) begin
        item_value   <= widen_word(rd_data);
        status       <= ST_DONE;
        carries_item <= 1'b1;
        last_result  <= end1;
      end else begin
        item_value   <= '0;
        status       <= status_r;
        carries_item <= 1'b0;
        last_result  <= 1'b1;
      end
    end
  end

endmodule
